[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scheduler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTTS_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTTS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[sv/ptts_pkg.sv]
// ---------------------------------------------------------------------------
// ptts_pkg
// Constants, codes and shared types of the periodic task tick scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int MAX_RESULTS = 8;
   localparam int DUE_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam int CMD_W       = 3;
   localparam int SLOT_IDX_W  = 8;
   localparam int PERIOD_W    = 16;
   localparam int TAG_W       = 8;
   localparam int TICK_STEP_W = 6;
   localparam int KIND_W      = 2;
   localparam int DUE_SLOT_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK,
      CMD_ADD,
      CMD_DELETE,
      CMD_SUSPEND,
      CMD_RESUME
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_STATUS,
      KIND_ACK,
      KIND_DUE,
      KIND_IDLE
   } kind_type;

   typedef enum logic [1:0] {
      MODE_READY,
      MODE_WAITING,
      MODE_SUSPENDED
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic tick_walk;
      logic search_walk;
      logic finish;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_last;
      logic tag_hit;
   } dp_status_type;

   // low bits of a slot number as reported on the due word
   function automatic logic [DUE_SLOT_W-1:0] due_slot_of(input logic [SLOT_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[DUE_SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[sv/ptts_ctrl.sv]
// ---------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: accepts commands, runs the slot walk and the finish step.
// ---------------------------------------------------------------------------
`default_nettype none

module ptts_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptts_pkg::CMD_W-1:0]    req_cmd,
   input  ptts_pkg::dp_status_type       status,
   output ptts_pkg::ctrl_cmd_type        ctrl,
   output logic                          busy
);
   import ptts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // finish drives only the result register and the slot it closes out, so a new word may enter there
   assign busy   = (state_ff == ST_TICK) || (state_ff == ST_SEARCH);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_FINISH: begin
            state_in = ST_IDLE;
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_TICK:                           state_in = ST_TICK;
                  CMD_ADD:                            state_in = ST_FINISH;
                  CMD_DELETE, CMD_SUSPEND, CMD_RESUME: state_in = ST_SEARCH;
                  default:                            state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (status.tag_hit || status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.load        = accept;
      ctrl.tick_walk   = (state_ff == ST_TICK);
      ctrl.search_walk = (state_ff == ST_SEARCH);
      ctrl.finish      = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/ptts_datapath.sv]
// ---------------------------------------------------------------------------
// ptts_datapath
// Slot table, walk counter, countdown arithmetic and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ptts_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ptts_pkg::ctrl_cmd_type              ctrl,
   output ptts_pkg::dp_status_type             status,
   input  logic [ptts_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ptts_pkg::SLOT_IDX_W-1:0]     req_slot_index,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_period_ms,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_first_delay_ms,
   input  logic [ptts_pkg::TAG_W-1:0]          req_task_tag,
   input  logic                                csr_write_en,
   input  logic [ptts_pkg::TICK_STEP_W-1:0]    csr_write_data,
   output logic                                rsp_strobe,
   output logic [ptts_pkg::KIND_W-1:0]         rsp_kind,
   output logic                                rsp_accepted,
   output logic [ptts_pkg::TAG_W-1:0]          rsp_due_tag,
   output logic [ptts_pkg::DUE_SLOT_W-1:0]     rsp_due_slot,
   output logic                                rsp_last
);
   import ptts_pkg::*;

   // held command word
   cmd_type                 cmd_ff, cmd_in;
   logic [SLOT_IDX_W-1:0]   slot_index_ff, slot_index_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic [PERIOD_W-1:0]     delay_ff, delay_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;

   logic [TICK_STEP_W-1:0]  step_ff, step_in;

   // walk state
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   logic                    hit_valid_ff, hit_valid_in;
   logic [SLOT_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [TAG_W-1:0]        pend_tag_ff, pend_tag_in;
   logic [DUE_SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [DUE_CNT_W-1:0]    due_cnt_ff, due_cnt_in;

   // slot table
   logic                    slot_used_ff [SLOT_COUNT];
   logic                    slot_used_in [SLOT_COUNT];
   logic [TAG_W-1:0]        slot_tag_ff  [SLOT_COUNT];
   logic [TAG_W-1:0]        slot_tag_in  [SLOT_COUNT];
   mode_type                slot_mode_ff [SLOT_COUNT];
   mode_type                slot_mode_in [SLOT_COUNT];
   logic [PERIOD_W-1:0]     slot_period_ff    [SLOT_COUNT];
   logic [PERIOD_W-1:0]     slot_countdown_ff [SLOT_COUNT];

   logic                    period_we;
   logic                    cd_we;
   logic [SLOT_W-1:0]       wr_idx;
   logic [PERIOD_W-1:0]     period_wdata;
   logic [PERIOD_W-1:0]     cd_wdata;

   // result register
   logic                    rsp_strobe_ff, rsp_strobe_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   logic [TAG_W-1:0]        rsp_due_tag_ff, rsp_due_tag_in;
   logic [DUE_SLOT_W-1:0]   rsp_due_slot_ff, rsp_due_slot_in;
   logic                    rsp_last_ff, rsp_last_in;

   // slot under the walk pointer
   logic                    cur_used;
   logic [TAG_W-1:0]        cur_tag;
   mode_type                cur_mode;
   logic [PERIOD_W-1:0]     cur_period;
   logic [PERIOD_W-1:0]     cur_cd;
   logic [PERIOD_W-1:0]     step_ext;
   logic [PERIOD_W-1:0]     reload;
   logic [PERIOD_W-1:0]     cd_next;
   logic [SLOT_W-1:0]       add_slot;
   logic                    add_ok;
   logic                    due_room;

   assign cur_used   = slot_used_ff[cnt_ff];
   assign cur_tag    = slot_tag_ff[cnt_ff];
   assign cur_mode   = slot_mode_ff[cnt_ff];
   assign cur_period = slot_period_ff[cnt_ff];
   assign cur_cd     = slot_countdown_ff[cnt_ff];
   assign step_ext   = {{(PERIOD_W-TICK_STEP_W){1'b0}}, step_ff};
   assign reload     = cur_period - step_ext;
   assign cd_next    = cur_cd - step_ext;

   assign add_slot   = slot_index_ff[SLOT_W-1:0];
   assign add_ok     = (slot_index_ff < SLOT_IDX_W'(SLOT_COUNT)) && !slot_used_ff[add_slot];
   assign due_room   = (due_cnt_ff < DUE_CNT_W'(MAX_RESULTS));

   assign status.walk_last = (cnt_ff == SLOT_W'(SLOT_COUNT - 1));
   assign status.tag_hit   = (cur_tag == tag_ff);

   always_comb begin
      cmd_in          = cmd_ff;
      slot_index_in   = slot_index_ff;
      period_in       = period_ff;
      delay_in        = delay_ff;
      tag_in          = tag_ff;
      step_in         = step_ff;
      cnt_in          = cnt_ff;
      hit_valid_in    = hit_valid_ff;
      hit_idx_in      = hit_idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_tag_in     = pend_tag_ff;
      pend_slot_in    = pend_slot_ff;
      due_cnt_in      = due_cnt_ff;
      slot_used_in    = slot_used_ff;
      slot_tag_in     = slot_tag_ff;
      slot_mode_in    = slot_mode_ff;
      period_we       = 1'b0;
      cd_we           = 1'b0;
      wr_idx          = cnt_ff;
      period_wdata    = period_ff;
      cd_wdata        = cd_next;
      rsp_strobe_in   = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_due_tag_in  = rsp_due_tag_ff;
      rsp_due_slot_in = rsp_due_slot_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_write_en) begin
         step_in = csr_write_data;
      end

      if (ctrl.load) begin
         cmd_in        = cmd_type'(req_cmd);
         slot_index_in = req_slot_index;
         period_in     = req_period_ms;
         delay_in      = req_first_delay_ms;
         tag_in        = req_task_tag;
         cnt_in        = '0;
         hit_valid_in  = 1'b0;
         pend_valid_in = 1'b0;
         due_cnt_in    = '0;
      end

      // one slot per cycle; a due word is held back one find so the
      // final one can carry last
      if (ctrl.tick_walk) begin
         cnt_in = cnt_ff + 1'b1;
         if (cur_used) begin
            if (cur_mode == MODE_READY) begin
               cd_we                = 1'b1;
               cd_wdata             = reload;
               slot_mode_in[cnt_ff] = MODE_WAITING;
               if (due_room) begin
                  if (pend_valid_ff) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_kind_in     = KIND_DUE;
                     rsp_accepted_in = 1'b1;
                     rsp_due_tag_in  = pend_tag_ff;
                     rsp_due_slot_in = pend_slot_ff;
                     rsp_last_in     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_tag_in   = cur_tag;
                  pend_slot_in  = due_slot_of(cnt_ff);
                  due_cnt_in    = due_cnt_ff + 1'b1;
               end
            end else if (cur_mode == MODE_WAITING) begin
               cd_we    = 1'b1;
               cd_wdata = cd_next;
               if (cd_next == '0) begin
                  slot_mode_in[cnt_ff] = MODE_READY;
               end
            end
         end
      end

      if (ctrl.search_walk) begin
         cnt_in = cnt_ff + 1'b1;
         if (status.tag_hit) begin
            hit_valid_in = 1'b1;
            hit_idx_in   = cnt_ff;
         end
      end

      if (ctrl.finish) begin
         rsp_strobe_in   = 1'b1;
         rsp_accepted_in = 1'b1;
         rsp_due_tag_in  = '0;
         rsp_due_slot_in = '0;
         rsp_last_in     = 1'b1;
         unique case (cmd_ff)
            CMD_TICK: begin
               if (pend_valid_ff) begin
                  rsp_kind_in     = KIND_DUE;
                  rsp_due_tag_in  = pend_tag_ff;
                  rsp_due_slot_in = pend_slot_ff;
               end else begin
                  rsp_kind_in = KIND_IDLE;
               end
            end
            CMD_ADD: begin
               rsp_kind_in     = KIND_ADD_STATUS;
               rsp_accepted_in = add_ok;
               if (add_ok) begin
                  slot_used_in[add_slot] = 1'b1;
                  slot_tag_in[add_slot]  = tag_ff;
                  slot_mode_in[add_slot] = (delay_ff == '0) ? MODE_READY : MODE_WAITING;
                  period_we              = 1'b1;
                  cd_we                  = 1'b1;
                  wr_idx                 = add_slot;
                  period_wdata           = period_ff;
                  cd_wdata               = delay_ff;
               end
            end
            CMD_DELETE: begin
               rsp_kind_in = KIND_ACK;
               if (hit_valid_ff) begin
                  slot_used_in[hit_idx_ff] = 1'b0;
               end
            end
            CMD_SUSPEND: begin
               rsp_kind_in = KIND_ACK;
               if (hit_valid_ff) begin
                  slot_mode_in[hit_idx_ff] = MODE_SUSPENDED;
               end
            end
            CMD_RESUME: begin
               rsp_kind_in = KIND_ACK;
               if (hit_valid_ff) begin
                  slot_mode_in[hit_idx_ff] = MODE_READY;
               end
            end
            default: rsp_strobe_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= TICK_STEP_W'(1);
         cnt_ff        <= '0;
         hit_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         due_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         slot_used_ff  <= '{default: 1'b0};
         slot_tag_ff   <= '{default: '0};
         slot_mode_ff  <= '{default: MODE_READY};
      end else begin
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         hit_valid_ff  <= hit_valid_in;
         pend_valid_ff <= pend_valid_in;
         due_cnt_ff    <= due_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         slot_used_ff  <= slot_used_in;
         slot_tag_ff   <= slot_tag_in;
         slot_mode_ff  <= slot_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      slot_index_ff   <= slot_index_in;
      period_ff       <= period_in;
      delay_ff        <= delay_in;
      tag_ff          <= tag_in;
      hit_idx_ff      <= hit_idx_in;
      pend_tag_ff     <= pend_tag_in;
      pend_slot_ff    <= pend_slot_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_due_tag_ff  <= rsp_due_tag_in;
      rsp_due_slot_ff <= rsp_due_slot_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // period and countdown: one write port each, valid only once added
   always_ff @(posedge clock) begin
      if (period_we) begin
         slot_period_ff[wr_idx] <= period_wdata;
      end
      if (cd_we) begin
         slot_countdown_ff[wr_idx] <= cd_wdata;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_due_tag  = rsp_due_tag_ff;
   assign rsp_due_slot = rsp_due_slot_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

[sv/periodic_task_tick_scheduler.sv]
// ---------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Tick: walks every slot (one slot per cycle), then a finish step in which the next word may start.
// Due words appear during the walk; the final word, flagged last, comes from the finish step.
// Add: goes straight to the finish step; a new word may start every cycle while busy is low.
// Delete/suspend/resume: id search stops at the first match or at the end of the table.
// Synchronous reset empties the table, zeroes the ids, sets tick_step to 1.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [ptts_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ptts_pkg::SLOT_IDX_W-1:0]     req_slot_index,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_period_ms,
   input  logic [ptts_pkg::PERIOD_W-1:0]       req_first_delay_ms,
   input  logic [ptts_pkg::TAG_W-1:0]          req_task_tag,
   // tick_step register
   input  logic                                csr_write_en,
   input  logic [ptts_pkg::TICK_STEP_W-1:0]    csr_write_data,
   // result channel, one word per strobe, no back-pressure
   output logic                                rsp_strobe,
   output logic [ptts_pkg::KIND_W-1:0]         rsp_kind,
   output logic                                rsp_accepted,
   output logic [ptts_pkg::TAG_W-1:0]          rsp_due_tag,
   output logic [ptts_pkg::DUE_SLOT_W-1:0]     rsp_due_slot,
   output logic                                rsp_last
);
   import ptts_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   // The controller sequences each word:
   //   tick   -> walk every slot in index order, then finish
   //   add    -> finish directly (write slot, report status)
   //   search -> walk until first id match or end of table, then finish
   // busy is only high during the walks; the finish cycle can take
   // the next word since it only touches the result register and the
   // slot being closed out.
   ptts_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   // The datapath holds the slot table, the walk pointer, the countdown
   // subtractors and a one-deep pending due word, so that the last due
   // word of a tick can be flagged once the walk is over.
   ptts_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_slot_index     (req_slot_index),
      .req_period_ms      (req_period_ms),
      .req_first_delay_ms (req_first_delay_ms),
      .req_task_tag       (req_task_tag),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_accepted       (rsp_accepted),
      .rsp_due_tag        (rsp_due_tag),
      .rsp_due_slot       (rsp_due_slot),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

[sv/ptts_checker.sv]
// ---------------------------------------------------------------------------
// ptts_checker
// Port-level checks on the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptts_props (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [ptts_pkg::CMD_W-1:0]          req_cmd,
   input  logic                                rsp_strobe,
   input  logic [ptts_pkg::KIND_W-1:0]         rsp_kind,
   input  logic                                rsp_accepted,
   input  logic [ptts_pkg::TAG_W-1:0]          rsp_due_tag,
   input  logic [ptts_pkg::DUE_SLOT_W-1:0]     rsp_due_slot,
   input  logic                                rsp_last
);
   import ptts_pkg::*;

   // a tick always walks the table
   `PTTS_ASSERT_NEXT(a_tick_walks, clock, reset, start && !busy && req_cmd == CMD_TICK, busy, "tick word did not start a walk")

   // only due words can be followed by more words of the same command
   `PTTS_ASSERT_IMPLY(a_single_last, clock, reset, rsp_strobe && rsp_kind != KIND_DUE, rsp_last, "non-due word without last")

   `PTTS_ASSERT_IMPLY(a_zero_fields, clock, reset, rsp_strobe && rsp_kind != KIND_DUE, rsp_due_tag == '0 && rsp_due_slot == '0, "non-due word carries task fields")

   `PTTS_ASSERT_IMPLY(a_accept_flag, clock, reset, rsp_strobe && rsp_kind != KIND_ADD_STATUS, rsp_accepted, "accepted low outside add status")

endmodule

bind periodic_task_tick_scheduler ptts_props u_ptts_checker (.*);

`default_nettype wire
